FILE: rtl/cppt_pkg.sv
package cppt_pkg;

    // Fixed widths of the stream fields and the minimum polygon size.
    localparam int unsigned IN_COORD_W = 16;
    localparam int unsigned BATCH_W    = 16;
    localparam int unsigned VCOUNT_W   = 6;
    localparam int unsigned MIN_POLY   = 3;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_STORED = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_TESTED = 2'd2,
        STAT_SMALL  = 2'd3
    } status_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic    capture;
        logic    exec;
        logic    scan_init;
        logic    scan_step;
        logic    finish;
        logic    set_winding;
        status_t code;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_test;
        logic load_full;
        logic load_third;
        logic too_small;
        logic issue_last;
        logic scan_done;
        logic out_busy;
    } stat_t;

endpackage

FILE: rtl/convex_polygon_point_test_core.sv
// Convex polygon point test. Vertices are loaded one word at a time into an
// internal vertex memory; query words are then tested against the stored
// polygon, and a query point counts as inside only when it lies strictly on
// the inner side of every edge, so points on an edge are outside. The winding
// direction is decided when the third vertex arrives, and inside points are
// counted per batch with saturation at the top of the 16-bit counter.
// Sequencing: an input word is taken only while the core is idle. A load that
// is not the third vertex, a load into a full store and a query against fewer
// than three vertices finish without an edge scan. The third vertex runs an
// edge scan for the winding check. A query against N vertices runs an edge
// loop that reads one vertex from the single-port vertex memory per cycle
// (N + 1 reads, the last one wrapping to vertex zero) and then drains a short
// difference, multiply and sign pipeline. A finished result sits in an output
// register; if it has not been taken when the next result is ready, the core
// holds until it is.
module convex_polygon_point_test_core #(
    parameter int unsigned MAX_VERTICES = 32,
    parameter int unsigned COORD_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_coord [15:0], y_coord [31:16]
    input  logic [1:0]  s_axis_tuser,   // cmd [0], start_new [1]
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // inside_res [0], inside_count [16:1],
                                        // vertex_count [22:17], zero [23]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);
    import cppt_pkg::*;

    cmd_t                 cmd;
    stat_t                st;
    status_t              out_status;
    logic                 out_inside;
    logic [BATCH_W-1:0]   out_batch;
    logic [VCOUNT_W-1:0]  out_vcount;

    // The controller sequences each word: capture, execute, an edge scan and
    // pipeline drain where one is needed, and result hand-off.
    cppt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the vertex memory, the polygon state, the edge
    // cross-product pipeline and the output register.
    cppt_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_axis_tuser[0]),
        .in_start   (s_axis_tuser[1]),
        .in_x       (s_axis_tdata[15:0]),
        .in_y       (s_axis_tdata[31:16]),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_inside (out_inside),
        .out_batch  (out_batch),
        .out_vcount (out_vcount)
    );

    // Result word packing, lowest field first, padded to a whole byte.
    assign m_axis_tdata = {1'b0, out_vcount, out_batch, out_inside};
    assign m_axis_tuser = out_status;

endmodule

FILE: rtl/cppt_ctrl.sv
module cppt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  cppt_pkg::stat_t st,
    output cppt_pkg::cmd_t  cmd
);
    import cppt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    wind_reg, wind_next;

    always_comb begin
        state_next      = state_reg;
        code_next       = code_reg;
        wind_next       = wind_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.code        = code_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec      = 1'b1;
                cmd.scan_init = 1'b1;
                wind_next     = 1'b0;
                if (st.is_test) begin
                    if (st.too_small) begin
                        code_next  = STAT_SMALL;
                        state_next = ST_FINISH;
                    end else begin
                        code_next  = STAT_TESTED;
                        state_next = ST_SCAN;
                    end
                end else if (st.load_full) begin
                    code_next  = STAT_FULL;
                    state_next = ST_FINISH;
                end else begin
                    code_next = STAT_STORED;
                    if (st.load_third) begin
                        wind_next  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (st.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!st.out_busy) begin
                    cmd.finish      = 1'b1;
                    cmd.set_winding = wind_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            code_reg  <= STAT_STORED;
            wind_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            wind_reg  <= wind_next;
        end
    end

    // A scan is entered only from the execute step.
    a_scan_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && $past(state_reg != ST_SCAN) |-> $past(state_reg == ST_EXEC))
        else $error("scan entered from wrong state");

    // Input is taken only while idle.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");

    // A finish always returns to idle.
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("finish did not return to idle");

endmodule

FILE: rtl/cppt_datapath.sv
module cppt_datapath #(
    parameter int unsigned MAX_VERTICES = 32,
    parameter int unsigned COORD_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_cmd,
    input  logic                                in_start,
    input  logic [cppt_pkg::IN_COORD_W-1:0]     in_x,
    input  logic [cppt_pkg::IN_COORD_W-1:0]     in_y,
    input  cppt_pkg::cmd_t                      cmd,
    output cppt_pkg::stat_t                     st,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cppt_pkg::status_t                   out_status,
    output logic                                out_inside,
    output logic [cppt_pkg::BATCH_W-1:0]        out_batch,
    output logic [cppt_pkg::VCOUNT_W-1:0]       out_vcount
);
    import cppt_pkg::*;

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned DW = CB + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned AW = $clog2(MAX_VERTICES);

    // Captured item
    logic                 cmd_reg;
    logic                 start_reg;
    logic signed [CB-1:0] px_reg, py_reg;

    // Polygon state
    logic [CW-1:0]        cnt_reg;
    logic                 cw_reg;
    logic [BATCH_W-1:0]   batch_reg;
    logic [BATCH_W-1:0]   batch_next;

    // Vertex memory, {y, x} per entry
    logic [2*CB-1:0]      mem [MAX_VERTICES];
    logic [2*CB-1:0]      rdata_reg;

    // Scan sequencing
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        eff_cnt;
    logic [AW-1:0]        rd_addr;
    logic                 rd_v_reg, first_reg, rlast_reg;

    // Edge pipeline
    logic signed [CB-1:0] rx, ry;
    logic signed [CB-1:0] prev_x_reg, prev_y_reg;
    logic                 a_v_reg, a_last_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, qx_reg, qy_reg;
    logic                 m_v_reg, m_last_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [PW-1:0] crs;
    logic                 crs_neg, edge_good;
    logic                 ok_reg, neg_reg, done_reg;

    // Output register
    logic                 ovalid_reg;
    status_t              ostatus_reg;
    logic                 oinside_reg;
    logic [BATCH_W-1:0]   obatch_reg;
    logic [VCOUNT_W-1:0]  ovcount_reg;

    assign eff_cnt = start_reg ? '0 : cnt_reg;

    assign st.is_test    = cmd_reg;
    assign st.load_full  = (eff_cnt == CW'(MAX_VERTICES));
    assign st.load_third = (eff_cnt == CW'(MIN_POLY - 1));
    assign st.too_small  = (cnt_reg < CW'(MIN_POLY));
    assign st.issue_last = cmd_reg ? (idx_reg == cnt_reg) : (idx_reg == CW'(1));
    assign st.scan_done  = done_reg;
    assign st.out_busy   = ovalid_reg && !out_ready;

    // The closing edge wraps back to vertex zero.
    assign rd_addr = (idx_reg == cnt_reg) ? '0 : idx_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= in_cmd;
            start_reg <= in_start;
            px_reg    <= CB'(in_x);
            py_reg    <= CB'(in_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && !cmd_reg && !st.load_full) begin
            mem[eff_cnt[AW-1:0]] <= {py_reg, px_reg};
        end
        if (cmd.scan_step) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            rd_v_reg  <= 1'b0;
            first_reg <= 1'b0;
            rlast_reg <= 1'b0;
        end else begin
            if (cmd.scan_init) begin
                idx_reg <= '0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + CW'(1);
            end
            rd_v_reg  <= cmd.scan_step;
            first_reg <= (idx_reg == '0);
            rlast_reg <= st.issue_last;
        end
    end

    assign rx = rdata_reg[CB-1:0];
    assign ry = rdata_reg[2*CB-1:CB];

    // Differences: edge vector and point offset from the edge start.
    always_ff @(posedge aclk) begin
        if (rd_v_reg) begin
            prev_x_reg <= rx;
            prev_y_reg <= ry;
            dx_reg     <= DW'(rx) - DW'(prev_x_reg);
            dy_reg     <= DW'(ry) - DW'(prev_y_reg);
            qx_reg     <= DW'(px_reg) - DW'(prev_x_reg);
            qy_reg     <= DW'(py_reg) - DW'(prev_y_reg);
        end
        p1_reg <= dx_reg * qy_reg;
        p2_reg <= dy_reg * qx_reg;
    end

    assign crs       = p1_reg - p2_reg;
    assign crs_neg   = crs[PW-1];
    assign edge_good = cw_reg ? crs_neg : (!crs_neg && (crs != '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg    <= 1'b0;
            a_last_reg <= 1'b0;
            m_v_reg    <= 1'b0;
            m_last_reg <= 1'b0;
            ok_reg     <= 1'b1;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            a_v_reg    <= rd_v_reg && !first_reg;
            a_last_reg <= rlast_reg;
            m_v_reg    <= a_v_reg;
            m_last_reg <= a_last_reg;
            done_reg   <= m_v_reg && m_last_reg;
            if (cmd.scan_init) begin
                ok_reg <= 1'b1;
            end else if (m_v_reg) begin
                ok_reg  <= ok_reg && edge_good;
                neg_reg <= crs_neg;
            end
        end
    end

    always_comb begin
        batch_next = batch_reg;
        if (cmd.exec && cmd_reg && start_reg) begin
            batch_next = '0;
        end else if (cmd.finish && (cmd.code == STAT_TESTED) && ok_reg
                     && (batch_reg != '1)) begin
            batch_next = batch_reg + BATCH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            cw_reg    <= 1'b0;
            batch_reg <= '0;
        end else begin
            batch_reg <= batch_next;
            if (cmd.exec && !cmd_reg && !st.load_full) begin
                cnt_reg <= eff_cnt + CW'(1);
                if (start_reg) begin
                    cw_reg <= 1'b0;
                end
            end
            if (cmd.set_winding) begin
                cw_reg <= neg_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            ostatus_reg <= cmd.code;
            oinside_reg <= (cmd.code == STAT_TESTED) && ok_reg;
            obatch_reg  <= batch_next;
            ovcount_reg <= VCOUNT_W'(cnt_reg);
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_status = ostatus_reg;
    assign out_inside = oinside_reg;
    assign out_batch  = obatch_reg;
    assign out_vcount = ovcount_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_cnt_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> $stable(cnt_reg))
        else $error("vertex count changed outside execute");

    a_scan_poly: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (cnt_reg >= CW'(MIN_POLY)))
        else $error("scan with fewer than three vertices");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(ovalid_reg && !out_ready))
        else $error("result overwritten while waiting");

endmodule
